// ===== rtl/pife_pkg.sv =====
// Shared types and constants of the pulse-interval frame encoder.
package pife_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int TIME_W      = 16;
   localparam int BYTE_W      = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_PULSE_WIDTH     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHORT_SPACE     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_SPACE      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_GAP       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CARRIER_COMPARE = 3'd4;

   localparam logic [TIME_W-1:0] PULSE_WIDTH_RESET     = 16'd200;
   localparam logic [TIME_W-1:0] SHORT_SPACE_RESET     = 16'd600;
   localparam logic [TIME_W-1:0] LONG_SPACE_RESET      = 16'd1400;
   localparam logic [TIME_W-1:0] FRAME_GAP_RESET       = 16'd3000;
   localparam logic [TIME_W-1:0] CARRIER_COMPARE_RESET = 16'd50;

   localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hAA;

   localparam int JOB_DEPTH_DEFAULT = 2;
   localparam int RSP_DEPTH_DEFAULT = 2;

   typedef enum logic {
      OP_START = 1'b0,
      OP_DATA  = 1'b1
   } opcode_type;

   typedef struct packed {
      logic [TIME_W-1:0] burst_us;
      logic [TIME_W-1:0] short_space_us;
      logic [TIME_W-1:0] long_space_us;
      logic [TIME_W-1:0] idle_gap_us;
      logic [TIME_W-1:0] carrier_compare;
   } cfg_type;

   // One unit of work for the symbol sequencer.
   typedef struct packed {
      opcode_type        kind;
      logic [BYTE_W-1:0] data;
      logic              trailer;
      logic [BYTE_W-1:0] checksum;
   } job_type;

   typedef struct packed {
      logic [TIME_W-1:0] carrier_level;
      logic [TIME_W-1:0] pulse_us;
      logic [TIME_W-1:0] space_us;
      logic              frame_end;
      logic              last;
   } sym_type;

endpackage

// ===== rtl/pife_fifo.sv =====
// Small register queue used for jobs and for finished symbols.
module pife_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_IDX) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/pife_front.sv =====
// Request classifier: tracks the open frame and turns requests into jobs.
module pife_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_accept,
   input  pife_pkg::opcode_type    req_opcode,
   input  logic [pife_pkg::BYTE_W-1:0] req_value,
   output logic                    job_push,
   output pife_pkg::job_type       job
);

   logic [pife_pkg::BYTE_W-1:0] bytes_left_ff, bytes_left_in;
   logic [pife_pkg::BYTE_W-1:0] running_sum_ff, running_sum_in;
   logic                        frame_open_ff, frame_open_in;
   logic [pife_pkg::BYTE_W-1:0] sum_next;
   logic [pife_pkg::BYTE_W-1:0] left_next;

   assign sum_next  = running_sum_ff + req_value;
   assign left_next = bytes_left_ff - 1'b1;

   always_comb begin
      bytes_left_in  = bytes_left_ff;
      running_sum_in = running_sum_ff;
      frame_open_in  = frame_open_ff;
      job_push       = 1'b0;
      job.kind       = req_opcode;
      job.data       = req_value;
      job.trailer    = 1'b0;
      job.checksum   = '0;
      if (req_accept) begin
         unique case (req_opcode)
            pife_pkg::OP_START: begin
               // Abandon any open frame; a zero length closes at once.
               job_push       = 1'b1;
               job.trailer    = (req_value == '0);
               running_sum_in = '0;
               bytes_left_in  = req_value;
               frame_open_in  = (req_value != '0);
            end
            pife_pkg::OP_DATA: begin
               // Drop data with no open frame.
               if (frame_open_ff && bytes_left_ff != '0) begin
                  job_push     = 1'b1;
                  job.trailer  = (left_next == '0);
                  job.checksum = sum_next;
                  if (left_next == '0) begin
                     running_sum_in = '0;
                     bytes_left_in  = '0;
                     frame_open_in  = 1'b0;
                  end else begin
                     running_sum_in = sum_next;
                     bytes_left_in  = left_next;
                  end
               end
            end
            default: begin
               job_push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff  <= '0;
         running_sum_ff <= '0;
         frame_open_ff  <= 1'b0;
      end else begin
         bytes_left_ff  <= bytes_left_in;
         running_sum_ff <= running_sum_in;
         frame_open_ff  <= frame_open_in;
      end
   end

endmodule

// ===== rtl/pife_back.sv =====
// Symbol sequencer: expands the job at the queue head into one symbol a cycle while sym_full is low.
module pife_back (
   input  logic              clock,
   input  logic              reset,
   input  pife_pkg::cfg_type cfg,
   input  logic              job_valid,
   input  pife_pkg::job_type job,
   output logic              job_pop,
   input  logic              sym_full,
   output logic              sym_push,
   output pife_pkg::sym_type sym
);

   typedef enum logic [2:0] {
      SEG_GAP,
      SEG_SYNC0,
      SEG_SYNC1,
      SEG_LEN,
      SEG_DATA,
      SEG_SUM,
      SEG_CLOSE
   } seg_type;

   seg_type    seg_ff, seg_in, cur_seg;
   logic [2:0] bit_ff, bit_in, cur_bit;
   logic       active_ff;
   logic [pife_pkg::BYTE_W-1:0] cur_byte;
   logic       cur_level_bit;

   // A fresh job starts at its first segment; a job in progress resumes.
   always_comb begin
      if (active_ff) begin
         cur_seg = seg_ff;
         cur_bit = bit_ff;
      end else begin
         cur_seg = (job.kind == pife_pkg::OP_START) ? SEG_GAP : SEG_DATA;
         cur_bit = 3'd7;
      end
   end

   always_comb begin
      unique case (cur_seg)
         SEG_SYNC0, SEG_SYNC1: cur_byte = pife_pkg::SYNC_BYTE;
         SEG_SUM:              cur_byte = job.checksum;
         default:              cur_byte = job.data;
      endcase
      cur_level_bit = cur_byte[cur_bit];
   end

   always_comb begin
      sym.carrier_level = cfg.carrier_compare;
      sym.pulse_us      = cfg.burst_us;
      sym.space_us      = cur_level_bit ? cfg.long_space_us : cfg.short_space_us;
      sym.frame_end     = 1'b0;
      sym.last          = 1'b0;
      seg_in            = cur_seg;
      bit_in            = cur_bit - 1'b1;
      unique case (cur_seg)
         SEG_GAP: begin
            sym.carrier_level = '0;
            sym.pulse_us      = cfg.idle_gap_us;
            sym.space_us      = '0;
            seg_in            = SEG_SYNC0;
            bit_in            = 3'd7;
         end
         SEG_CLOSE: begin
            sym.space_us  = '0;
            sym.frame_end = 1'b1;
            sym.last      = 1'b1;
            seg_in        = SEG_GAP;
            bit_in        = 3'd7;
         end
         SEG_SYNC0, SEG_SYNC1, SEG_LEN, SEG_DATA, SEG_SUM: begin
            if (cur_bit == 3'd0) begin
               bit_in = 3'd7;
               unique case (cur_seg)
                  SEG_SYNC0: seg_in = SEG_SYNC1;
                  SEG_SYNC1: seg_in = SEG_LEN;
                  SEG_SUM:   seg_in = SEG_CLOSE;
                  default: begin
                     seg_in   = SEG_SUM;
                     sym.last = !job.trailer;
                  end
               endcase
            end
         end
         default: begin
            seg_in = SEG_GAP;
         end
      endcase
   end

   assign sym_push = job_valid && !sym_full;
   assign job_pop  = sym_push && sym.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         seg_ff    <= SEG_GAP;
         bit_ff    <= 3'd7;
      end else if (sym_push) begin
         active_ff <= !sym.last;
         seg_ff    <= seg_in;
         bit_ff    <= bit_in;
      end
   end

   a_pop_on_last: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> (sym_push && sym.last))
      else $error("job retired without its last symbol");

   a_active_has_job: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> job_valid)
      else $error("sequencer in progress with no job at the queue head");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (active_ff && !sym_push) |=> ($stable(seg_ff) && $stable(bit_ff)))
      else $error("sequencer moved while stalled");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (sym_push && sym.frame_end) |-> (sym.last && job.trailer))
      else $error("closing pulse not the final symbol of a closing job");

endmodule

// ===== rtl/pulse_interval_frame_encoder.sv =====
// Top level of the pulse-interval frame encoder for an infrared link.
//
// Each request is a start (opcode 0, value = frame length) or a payload byte
// (opcode 1). Each response is one symbol: a carrier burst at carrier_level
// for pulse_us, then carrier off for space_us. A start yields the idle gap,
// two 0xAA sync bytes and the length byte (25 symbols); a payload byte yields
// eight symbols, MSB first, with a short space for 0 and a long space for 1.
// The byte that ends a frame, or a zero-length start, also yields the 8-bit
// checksum and one closing pulse (frame_end = 1), nine symbols more. Payload
// with no open frame is taken and dropped; a start abandons an open frame.
// Timing: the symbol sequencer emits one symbol per clock while a job is
// queued and the response queue has room. The front classifier takes a
// request every cycle while the job queue has room, so it runs ahead of
// the sequencer by the queue depth; the sequencer stalls only while the
// response queue is full. A request is registered in the job queue, then
// its first symbol in the response queue, before it appears. The CSR port is
// always ready; write registers only while the block is idle.
module pulse_interval_frame_encoder #(
   parameter int JOB_DEPTH = pife_pkg::JOB_DEPTH_DEFAULT,
   parameter int RSP_DEPTH = pife_pkg::RSP_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // request queue side
   input  logic                                req_push,
   output logic                                req_full,
   input  logic                                req_opcode,
   input  logic [pife_pkg::BYTE_W-1:0]         req_value,
   // response queue side
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [pife_pkg::TIME_W-1:0]         rsp_carrier_level,
   output logic [pife_pkg::TIME_W-1:0]         rsp_pulse_us,
   output logic [pife_pkg::TIME_W-1:0]         rsp_space_us,
   output logic                                rsp_frame_end,
   output logic                                rsp_last,
   // register write port
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pife_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pife_pkg::TIME_W-1:0]         csr_wdata
);

   localparam int JOB_W = $bits(pife_pkg::job_type);
   localparam int SYM_W = $bits(pife_pkg::sym_type);

   pife_pkg::cfg_type cfg_ff, cfg_in;
   logic              csr_write;

   logic              req_accept;
   logic              job_push, job_full, job_empty, job_pop;
   pife_pkg::job_type job_in, job_head;
   logic [JOB_W-1:0]  job_head_bits;

   logic              sym_push, sym_full;
   pife_pkg::sym_type sym, rsp_sym;
   logic [SYM_W-1:0]  rsp_bits;

   // Register file: five timing/level registers, unknown indexes ignored.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            pife_pkg::CSR_PULSE_WIDTH:     cfg_in.burst_us        = csr_wdata;
            pife_pkg::CSR_SHORT_SPACE:     cfg_in.short_space_us  = csr_wdata;
            pife_pkg::CSR_LONG_SPACE:      cfg_in.long_space_us   = csr_wdata;
            pife_pkg::CSR_FRAME_GAP:       cfg_in.idle_gap_us     = csr_wdata;
            pife_pkg::CSR_CARRIER_COMPARE: cfg_in.carrier_compare = csr_wdata;
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.burst_us        <= pife_pkg::PULSE_WIDTH_RESET;
         cfg_ff.short_space_us  <= pife_pkg::SHORT_SPACE_RESET;
         cfg_ff.long_space_us   <= pife_pkg::LONG_SPACE_RESET;
         cfg_ff.idle_gap_us     <= pife_pkg::FRAME_GAP_RESET;
         cfg_ff.carrier_compare <= pife_pkg::CARRIER_COMPARE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: accept a request whenever the job queue has room.
   assign req_full   = job_full;
   assign req_accept = req_push && !req_full;

   pife_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_opcode (pife_pkg::opcode_type'(req_opcode)),
      .req_value  (req_value),
      .job_push   (job_push),
      .job        (job_in)
   );

   // Job queue between classifier and sequencer.
   pife_fifo #(
      .WIDTH (JOB_W),
      .DEPTH (JOB_DEPTH)
   ) u_job_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (job_head_bits),
      .empty     (job_empty)
   );

   assign job_head = pife_pkg::job_type'(job_head_bits);

   // Back: expand the head job into symbols.
   pife_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_valid (!job_empty),
      .job       (job_head),
      .job_pop   (job_pop),
      .sym_full  (sym_full),
      .sym_push  (sym_push),
      .sym       (sym)
   );

   // Response queue: hold finished symbols until the consumer pops them.
   pife_fifo #(
      .WIDTH (SYM_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (sym_push),
      .push_data (sym),
      .full      (sym_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_bits),
      .empty     (rsp_empty)
   );

   assign rsp_sym           = pife_pkg::sym_type'(rsp_bits);
   assign rsp_carrier_level = rsp_sym.carrier_level;
   assign rsp_pulse_us      = rsp_sym.pulse_us;
   assign rsp_space_us      = rsp_sym.space_us;
   assign rsp_frame_end     = rsp_sym.frame_end;
   assign rsp_last          = rsp_sym.last;

endmodule

// ===== tb/tb_pulse_interval_frame_encoder.sv =====
// Self-checking testbench for the pulse-interval frame encoder top level.
`timescale 1ns / 100ps

module tb_pulse_interval_frame_encoder;

   // Run bounds: the cycle limit covers every request at its worst case
   // (34 symbols each) behind a heavily stalling receiver, several times over.
   localparam int LIMIT_CYCLES          = 1000000;
   localparam int SETTLE_CYCLES         = 40;
   localparam int RANDOM_ITEMS_PER_PASS = 67;
   localparam int RANDOM_PASSES         = 6;
   localparam int DIRECTED_ROWS         = 17;

   // Indexes past the last register; writes there must change nothing.
   localparam logic [pife_pkg::CSR_INDEX_W-1:0] CSR_SPARE_FIRST = 3'd5;
   localparam logic [pife_pkg::CSR_INDEX_W-1:0] CSR_SPARE_LAST  = 3'd7;

   // Final symbols that can be read straight off the reset settings.
   localparam pife_pkg::sym_type NO_SYMBOL     = '0;
   localparam pife_pkg::sym_type CLOSING_PULSE =
      {pife_pkg::CARRIER_COMPARE_RESET, pife_pkg::PULSE_WIDTH_RESET, 16'd0, 1'b1, 1'b1};
   localparam pife_pkg::sym_type ONE_BIT_LAST  =
      {pife_pkg::CARRIER_COMPARE_RESET, pife_pkg::PULSE_WIDTH_RESET,
       pife_pkg::LONG_SPACE_RESET, 1'b0, 1'b1};
   localparam pife_pkg::sym_type ZERO_BIT_LAST =
      {pife_pkg::CARRIER_COMPARE_RESET, pife_pkg::PULSE_WIDTH_RESET,
       pife_pkg::SHORT_SPACE_RESET, 1'b0, 1'b1};

   // One directed request; the symbol count and the final symbol are typed in
   // only where they are obvious, otherwise the predictor alone decides.
   typedef struct packed {
      pife_pkg::opcode_type        op;
      logic [pife_pkg::BYTE_W-1:0] value;
      logic                        count_typed;
      logic [5:0]                  count;
      logic                        tail_typed;
      pife_pkg::sym_type           tail;
   } directed_row_type;

   logic                             clock             = 1'b0;
   logic                             reset             = 1'b1;
   logic                             req_push          = 1'b0;
   logic                             req_full;
   logic                             req_opcode        = 1'b0;
   logic [pife_pkg::BYTE_W-1:0]      req_value         = '0;
   logic                             rsp_empty;
   logic                             rsp_pop           = 1'b0;
   logic [pife_pkg::TIME_W-1:0]      rsp_carrier_level;
   logic [pife_pkg::TIME_W-1:0]      rsp_pulse_us;
   logic [pife_pkg::TIME_W-1:0]      rsp_space_us;
   logic                             rsp_frame_end;
   logic                             rsp_last;
   logic                             csr_valid         = 1'b0;
   logic                             csr_ready;
   logic [pife_pkg::CSR_INDEX_W-1:0] csr_index         = '0;
   logic [pife_pkg::TIME_W-1:0]      csr_wdata         = '0;

   // Predictor copy of the registers and the frame state.
   pife_pkg::cfg_type           csr_shadow;
   logic [pife_pkg::BYTE_W-1:0] frame_bytes_left;
   logic [pife_pkg::BYTE_W-1:0] frame_checksum;
   logic                        frame_is_open;

   // Symbols of the latest request, and every symbol still owed by the block.
   pife_pkg::sym_type step_symbols[$];
   pife_pkg::sym_type pending_symbols[$];

   int error_count       = 0;
   int symbol_count      = 0;
   int cycle_count       = 0;
   int sender_idle_pct   = 0;
   int receiver_idle_pct = 0;

   directed_row_type directed_rows [DIRECTED_ROWS];

   pulse_interval_frame_encoder uut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_opcode        (req_opcode),
      .req_value         (req_value),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_carrier_level (rsp_carrier_level),
      .rsp_pulse_us      (rsp_pulse_us),
      .rsp_space_us      (rsp_space_us),
      .rsp_frame_end     (rsp_frame_end),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #1 clock = ~clock;

   // Print one line per mismatch and count it.
   task automatic flag_mismatch(input string msg);
      error_count++;
      $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   // ---------------------------------------------------------------- predictor

   function automatic void stage_symbol(input logic [pife_pkg::TIME_W-1:0] level,
                                        input logic [pife_pkg::TIME_W-1:0] pulse,
                                        input logic [pife_pkg::TIME_W-1:0] space,
                                        input logic                        closing);
      pife_pkg::sym_type sym;
      sym.carrier_level = level;
      sym.pulse_us      = pulse;
      sym.space_us      = space;
      sym.frame_end     = closing;
      sym.last          = 1'b0;
      step_symbols.push_back(sym);
   endfunction

   // Emit a byte MSB first: one pulse per bit, the space carries the bit.
   function automatic void stage_byte(input logic [pife_pkg::BYTE_W-1:0] data);
      for (int i = pife_pkg::BYTE_W - 1; i >= 0; i--) begin
         stage_symbol(csr_shadow.carrier_compare, csr_shadow.burst_us,
                      data[i] ? csr_shadow.long_space_us : csr_shadow.short_space_us,
                      1'b0);
      end
   endfunction

   // Close the frame: checksum byte, then the closing pulse with no space.
   function automatic void stage_trailer();
      stage_byte(frame_checksum);
      stage_symbol(csr_shadow.carrier_compare, csr_shadow.burst_us, '0, 1'b1);
      frame_is_open    = 1'b0;
      frame_bytes_left = '0;
      frame_checksum   = '0;
   endfunction

   // Work out the symbols that one accepted request causes, queue them as
   // owed, and return how many there are.
   function automatic int encode_request(input pife_pkg::opcode_type op,
                                         input logic [pife_pkg::BYTE_W-1:0] value);
      pife_pkg::sym_type tail;
      step_symbols.delete();
      if (op == pife_pkg::OP_START) begin
         // A start always restarts the frame, abandoning any open one.
         frame_checksum   = '0;
         frame_bytes_left = value;
         frame_is_open    = 1'b1;
         stage_symbol('0, csr_shadow.idle_gap_us, '0, 1'b0);
         stage_byte(pife_pkg::SYNC_BYTE);
         stage_byte(pife_pkg::SYNC_BYTE);
         stage_byte(value);
         if (frame_bytes_left == '0) begin
            stage_trailer();
         end
      end else if (frame_is_open && frame_bytes_left != '0) begin
         stage_byte(value);
         frame_checksum   = frame_checksum + value;
         frame_bytes_left = frame_bytes_left - 1'b1;
         if (frame_bytes_left == '0) begin
            stage_trailer();
         end
      end
      // Payload with no open frame falls through: dropped, no symbols.
      if (step_symbols.size() != 0) begin
         tail      = step_symbols.pop_back();
         tail.last = 1'b1;
         step_symbols.push_back(tail);
      end
      foreach (step_symbols[k]) begin
         pending_symbols.push_back(step_symbols[k]);
      end
      return step_symbols.size();
   endfunction

   // ---------------------------------------------------------------- drivers

   // Offer one request, idling first at the current sender rate; push stays
   // high on return so back-to-back requests need no extra edge.
   task automatic send_request(input pife_pkg::opcode_type op,
                               input logic [pife_pkg::BYTE_W-1:0] value,
                               output int produced);
      while ($urandom_range(99, 0) < sender_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push   <= 1'b1;
      req_opcode <= op;
      req_value  <= value;
      do @(posedge clock); while (req_full);
      produced = encode_request(op, value);
   endtask

   // Hold requests off until every owed symbol has come, then let the block
   // settle. It always waits on the clock before it first tests what is owed.
   task automatic drain_symbols(input int settle);
      req_push <= 1'b0;
      do @(posedge clock); while (pending_symbols.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_register(input logic [pife_pkg::CSR_INDEX_W-1:0] index,
                                 input logic [pife_pkg::TIME_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         pife_pkg::CSR_PULSE_WIDTH:     csr_shadow.burst_us        = data;
         pife_pkg::CSR_SHORT_SPACE:     csr_shadow.short_space_us  = data;
         pife_pkg::CSR_LONG_SPACE:      csr_shadow.long_space_us   = data;
         pife_pkg::CSR_FRAME_GAP:       csr_shadow.idle_gap_us     = data;
         pife_pkg::CSR_CARRIER_COMPARE: csr_shadow.carrier_compare = data;
         default: ;
      endcase
   endtask

   // Write all five registers plus one unused index, then drop valid.
   task automatic load_settings(input pife_pkg::cfg_type cfg);
      write_register(pife_pkg::CSR_PULSE_WIDTH, cfg.burst_us);
      write_register(pife_pkg::CSR_SHORT_SPACE, cfg.short_space_us);
      write_register(pife_pkg::CSR_LONG_SPACE, cfg.long_space_us);
      write_register(pife_pkg::CSR_FRAME_GAP, cfg.idle_gap_us);
      write_register(pife_pkg::CSR_CARRIER_COMPARE, cfg.carrier_compare);
      write_register(
         pife_pkg::CSR_INDEX_W'($urandom_range(CSR_SPARE_LAST, CSR_SPARE_FIRST)),
         pife_pkg::TIME_W'($urandom()));
      csr_valid <= 1'b0;
   endtask

   // Mostly well-formed frames with random payload; some are cut short (the
   // next start abandons them), some long lengths, and some stray payload
   // that the block must drop. Dropped requests do not count toward quota.
   task automatic run_random_frames(input int quota);
      int taken;
      int len;
      int nbytes;
      int produced;
      taken = 0;
      while (taken < quota) begin
         if ($urandom_range(99, 0) < 8) begin
            send_request(pife_pkg::OP_DATA, pife_pkg::BYTE_W'($urandom_range(255, 0)),
                         produced);
            taken += (produced != 0);
         end
         len = ($urandom_range(99, 0) < 85) ? $urandom_range(6, 0)
                                            : $urandom_range(255, 7);
         send_request(pife_pkg::OP_START, pife_pkg::BYTE_W'(len), produced);
         taken++;
         nbytes = len;
         if (len > 12 || $urandom_range(99, 0) < 12) begin
            nbytes = $urandom_range((len < 12) ? len : 12, 0);
         end
         for (int k = 0; k < nbytes; k++) begin
            // Now and then pause mid-frame until the block has caught up.
            if ($urandom_range(49, 0) == 0) begin
               drain_symbols(0);
            end
            send_request(pife_pkg::OP_DATA, pife_pkg::BYTE_W'($urandom_range(255, 0)),
                         produced);
            taken++;
         end
      end
   endtask

   // ---------------------------------------------------------------- checker

   task automatic check_symbol();
      pife_pkg::sym_type want;
      symbol_count++;
      if (pending_symbols.size() == 0) begin
         flag_mismatch($sformatf("symbol %0d arrived with none owed", symbol_count));
         return;
      end
      want = pending_symbols.pop_front();
      if (rsp_carrier_level !== want.carrier_level)
         flag_mismatch($sformatf("symbol %0d carrier_level %0d, expected %0d",
                                 symbol_count, rsp_carrier_level, want.carrier_level));
      if (rsp_pulse_us !== want.pulse_us)
         flag_mismatch($sformatf("symbol %0d pulse_us %0d, expected %0d",
                                 symbol_count, rsp_pulse_us, want.pulse_us));
      if (rsp_space_us !== want.space_us)
         flag_mismatch($sformatf("symbol %0d space_us %0d, expected %0d",
                                 symbol_count, rsp_space_us, want.space_us));
      if (rsp_frame_end !== want.frame_end)
         flag_mismatch($sformatf("symbol %0d frame_end %b, expected %b",
                                 symbol_count, rsp_frame_end, want.frame_end));
      if (rsp_last !== want.last)
         flag_mismatch($sformatf("symbol %0d last %b, expected %b",
                                 symbol_count, rsp_last, want.last));
   endtask

   // Sample at the edge (pre-update values), then pick the next pop level.
   initial begin : response_side
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            check_symbol();
         end
         rsp_pop <= ($urandom_range(99, 0) >= receiver_idle_pct);
      end
   end

   // Watchdog: stop a hung run.
   initial begin : watchdog
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   // ---------------------------------------------------------------- stimulus

   initial begin : stimulus
      pife_pkg::cfg_type cfg;
      directed_row_type  row;
      int                produced;

      csr_shadow.burst_us        = pife_pkg::PULSE_WIDTH_RESET;
      csr_shadow.short_space_us  = pife_pkg::SHORT_SPACE_RESET;
      csr_shadow.long_space_us   = pife_pkg::LONG_SPACE_RESET;
      csr_shadow.idle_gap_us     = pife_pkg::FRAME_GAP_RESET;
      csr_shadow.carrier_compare = pife_pkg::CARRIER_COMPARE_RESET;
      frame_bytes_left = '0;
      frame_checksum   = '0;
      frame_is_open    = 1'b0;

      // Directed requests at the reset settings: payload with no frame,
      // zero-length frame, full frames, abandon by a new start, extremes.
      directed_rows = '{
         '{pife_pkg::OP_DATA,  8'hFF, 1'b1, 6'd0,  1'b0, NO_SYMBOL},     // no frame yet
         '{pife_pkg::OP_START, 8'h00, 1'b1, 6'd34, 1'b1, CLOSING_PULSE}, // zero length
         '{pife_pkg::OP_DATA,  8'h00, 1'b1, 6'd0,  1'b0, NO_SYMBOL},     // frame closed
         '{pife_pkg::OP_START, 8'h03, 1'b1, 6'd25, 1'b1, ONE_BIT_LAST},
         '{pife_pkg::OP_DATA,  8'h00, 1'b0, 6'd0,  1'b0, NO_SYMBOL},
         '{pife_pkg::OP_DATA,  8'hFF, 1'b0, 6'd0,  1'b0, NO_SYMBOL},
         '{pife_pkg::OP_DATA,  8'h80, 1'b1, 6'd17, 1'b1, CLOSING_PULSE},
         '{pife_pkg::OP_DATA,  8'h5A, 1'b1, 6'd0,  1'b0, NO_SYMBOL},     // dropped
         '{pife_pkg::OP_START, 8'hFF, 1'b1, 6'd25, 1'b1, ONE_BIT_LAST},  // longest
         '{pife_pkg::OP_DATA,  8'h01, 1'b0, 6'd0,  1'b0, NO_SYMBOL},
         '{pife_pkg::OP_DATA,  8'hFE, 1'b0, 6'd0,  1'b0, NO_SYMBOL},
         '{pife_pkg::OP_START, 8'h02, 1'b1, 6'd25, 1'b1, ZERO_BIT_LAST}, // abandons
         '{pife_pkg::OP_DATA,  8'hFF, 1'b0, 6'd0,  1'b0, NO_SYMBOL},
         '{pife_pkg::OP_DATA,  8'hFF, 1'b1, 6'd17, 1'b1, CLOSING_PULSE}, // sum wraps
         '{pife_pkg::OP_START, 8'h01, 1'b1, 6'd25, 1'b1, ONE_BIT_LAST},
         '{pife_pkg::OP_DATA,  8'h7F, 1'b1, 6'd17, 1'b1, CLOSING_PULSE},
         '{pife_pkg::OP_DATA,  8'h00, 1'b1, 6'd0,  1'b0, NO_SYMBOL}      // after close
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct   = 36;
      receiver_idle_pct = 61;
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         row = directed_rows[r];
         send_request(row.op, row.value, produced);
         if (row.count_typed && produced != int'(row.count))
            flag_mismatch($sformatf("directed row %0d: %0d symbols predicted, %0d typed",
                                    r, produced, row.count));
         if (row.tail_typed && produced != 0 && step_symbols[$] != row.tail)
            flag_mismatch($sformatf("directed row %0d: final symbol %h, typed %h",
                                    r, step_symbols[$], row.tail));
      end
      drain_symbols(SETTLE_CYCLES);

      // Random passes: two per idling mode (sender-heavy, receiver-heavy, none),
      // each under its own register settings, the extremes among them.
      for (int p = 0; p < RANDOM_PASSES; p++) begin
         case (p / 2)
            0:       begin sender_idle_pct = 36; receiver_idle_pct = 61; end
            1:       begin sender_idle_pct = 61; receiver_idle_pct = 36; end
            default: begin sender_idle_pct = 0;  receiver_idle_pct = 0;  end
         endcase
         cfg.burst_us        = pife_pkg::TIME_W'($urandom_range(65535, 1));
         cfg.short_space_us  = pife_pkg::TIME_W'($urandom_range(65535, 1));
         cfg.long_space_us   = pife_pkg::TIME_W'($urandom_range(65535, 1));
         cfg.idle_gap_us     = pife_pkg::TIME_W'($urandom_range(65535, 0));
         cfg.carrier_compare = pife_pkg::TIME_W'($urandom_range(65535, 0));
         if (p == 0) begin
            cfg = {16'd1, 16'd1, 16'd65535, 16'd0, 16'd0};
         end else if (p == 2) begin
            cfg = {16'd65535, 16'd65535, 16'd1, 16'd65535, 16'd65535};
         end
         load_settings(cfg);
         run_random_frames(RANDOM_ITEMS_PER_PASS);
         drain_symbols(SETTLE_CYCLES);
      end

      if (error_count == 0 && pending_symbols.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
